@@ rtl/dbh_pkg.sv @@
// ----------------------------------------------------------------------------
// dbh_pkg
// Shared types, constants and fixed-point helpers of the damped BFGS block.
// ----------------------------------------------------------------------------
package dbh_pkg;

  localparam int MAX_VARS  = 32;
  localparam int IDX_W     = $clog2(MAX_VARS);
  localparam int CNT_W     = $clog2(MAX_VARS + 1);
  localparam int FRAC_BITS = 16;
  localparam int H_DEPTH   = MAX_VARS * MAX_VARS;
  localparam int H_AW      = 2 * IDX_W;
  localparam int VAL_W     = 32;
  localparam int ACC_W     = 56;
  localparam int MA_W      = 34;
  localparam int PROD_W    = MA_W + VAL_W;
  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 40;
  localparam int DIV_CNT_W = 7;
  localparam int CFG_W     = 6;
  localparam int CMD_W     = 3;
  localparam int IN_W      = 144;
  localparam int OUT_W     = 40;

  localparam logic signed [VAL_W-1:0] Q_ONE   = VAL_W'(64'd1 << FRAC_BITS);
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFFFFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;
  localparam logic signed [ACC_W-1:0] ACC_MAX32 = ACC_W'(64'sh000000007FFFFFFF);
  localparam logic signed [ACC_W-1:0] ACC_MIN32 = ACC_W'(-64'sh0000000080000000);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_VAR    = 3'd1,
    CMD_JAC    = 3'd2,
    CMD_UPDATE = 3'd3,
    CMD_READ   = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    K_QS,
    K_HROW,
    K_SHS,
    K_QQ,
    K_QS2
  } dot_kind_t;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_JSUB,
    ST_JMUL,
    ST_JACC,
    ST_RD_ISSUE,
    ST_RESP,
    ST_U_START,
    ST_DOT_ISSUE,
    ST_DOT_MUL,
    ST_DOT_ACC,
    ST_DOT_END,
    ST_RS_GO,
    ST_RS_WAIT,
    ST_RS_WR,
    ST_DP_CHECK,
    ST_DP_GO,
    ST_DP_WAIT,
    ST_DP_M1,
    ST_DP_M2,
    ST_DP_SUM,
    ST_UP_ROW,
    ST_UP_M1,
    ST_UP_D1,
    ST_UP_W1,
    ST_UP_M2,
    ST_UP_D2,
    ST_UP_W2,
    ST_UP_WR
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             busy;
    logic [VAL_W-1:0] quot;
    logic             sat;
  } div_rsp_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > ACC_MAX32) begin
      return VAL_MAX;
    end else if (v < ACC_MIN32) begin
      return VAL_MIN;
    end
    return v[VAL_W-1:0];
  endfunction

  function automatic logic ovf32(input logic signed [ACC_W-1:0] v);
    return (v > ACC_MAX32) || (v < ACC_MIN32);
  endfunction

  // floor shift of a product back to the value scale
  function automatic logic signed [ACC_W-1:0] asr_q(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p >>> FRAC_BITS;
    return t[ACC_W-1:0];
  endfunction

endpackage

@@ rtl/dbh_ram.sv @@
// ----------------------------------------------------------------------------
// dbh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dbh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/dbh_div.sv @@
// ----------------------------------------------------------------------------
// dbh_div
// Radix-2 restoring divider, one quotient bit per cycle, clamped to 32 bits.
// ----------------------------------------------------------------------------
module dbh_div import dbh_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic                 sat;
  logic [VAL_W-1:0]     quot;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_NUM_W-1:0] un;
  logic [DIV_DEN_W:0]   ud;
  logic [DIV_DEN_W:0]   rem;
  logic [DIV_NUM_W-1:0] qt;
  logic                 neg;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 fits;

  assign rem_sh = {rem[DIV_DEN_W-1:0], un[DIV_NUM_W-1]};
  assign fits   = rem_sh >= ud;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        if (req.den == '0) begin
          done <= 1'b1;
          sat  <= 1'b1;
          quot <= req.num[DIV_NUM_W-1] ? VAL_MIN : VAL_MAX;
        end else begin
          busy <= 1'b1;
          cnt  <= DIV_CNT_W'(DIV_NUM_W);
          neg  <= req.num[DIV_NUM_W-1] ^ req.den[DIV_DEN_W-1];
          un   <= req.num[DIV_NUM_W-1] ? (~req.num + 1'b1) : req.num;
          ud   <= {1'b0, req.den[DIV_DEN_W-1] ? (~req.den + 1'b1) : req.den};
          rem  <= '0;
          qt   <= '0;
        end
      end else if (busy) begin
        if (cnt != '0) begin
          cnt <= cnt - 1'b1;
          un  <= {un[DIV_NUM_W-2:0], 1'b0};
          rem <= fits ? (rem_sh - ud) : rem_sh;
          qt  <= {qt[DIV_NUM_W-2:0], fits};
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
          if (!neg) begin
            if (qt > DIV_NUM_W'(64'h7FFFFFFF)) begin
              sat  <= 1'b1;
              quot <= VAL_MAX;
            end else begin
              sat  <= 1'b0;
              quot <= qt[VAL_W-1:0];
            end
          end else if (qt > DIV_NUM_W'(64'h80000000)) begin
            sat  <= 1'b1;
            quot <= VAL_MIN;
          end else begin
            sat  <= 1'b0;
            quot <= ~qt[VAL_W-1:0] + 1'b1;
          end
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.busy = busy;
  assign rsp.quot = quot;
  assign rsp.sat  = sat;

endmodule

@@ rtl/damped_bfgs_hessian_update.sv @@
// ----------------------------------------------------------------------------
// damped_bfgs_hessian_update
// Powell-damped BFGS update of an n-by-n Q16.16 Hessian held in block RAM.
// ----------------------------------------------------------------------------
// path: clear and variable items EXEC, RESP; jacobian items add JSUB, JMUL, JACC; reads add RD_ISSUE
// update: run time set by the bit-serial divider
//   (two divisions per Hessian entry) and the shared multiplier
// throughput: one request at a time; the next is taken once the result is out
// reset: synchronous, then an init pass writes the identity into all 1024 entries of the RAM
// ----------------------------------------------------------------------------
module damped_bfgs_hessian_update import dbh_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // command, row_index, col_index, first_value, second_value, third_value,
  // fourth_value
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // read_value, update_done, damping_applied, rescale_applied, saturated
  output logic [OUT_W-1:0] m_tdata,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  state_t    state, state_next;
  dot_kind_t kind;

  logic [CFG_W-1:0] vars_in_use;
  logic [CNT_W-1:0] n_act;

  logic [CMD_W-1:0] cmd;
  logic [IDX_W-1:0] row_index, col_index;
  logic signed [VAL_W-1:0] v1, v2, v3, v4;

  logic signed [VAL_W-1:0] s_vec  [MAX_VARS];
  logic signed [VAL_W-1:0] q_vec  [MAX_VARS];
  logic signed [VAL_W-1:0] qd_vec [MAX_VARS];
  logic signed [VAL_W-1:0] hs_vec [MAX_VARS];

  logic [CNT_W-1:0] ri, cj;
  logic [CNT_W-1:0] ri_inc, cj_inc;
  logic             last_i, last_j;
  logic [IDX_W-1:0] vidx;
  logic [H_AW-1:0]  init_addr;

  logic signed [ACC_W-1:0]  acc, tmp_a;
  logic signed [PROD_W-1:0] prod;
  logic signed [MA_W-1:0]   ma;
  logic signed [VAL_W-1:0]  mb;
  logic signed [VAL_W-1:0]  qs, shs, qq, th, scale, t1, t2, qrow, hrow, dreg;
  logic signed [VAL_W-1:0]  vq, vs, vh, acc_sat, rdata_s;
  logic                     acc_ovf;

  logic sat_f, damp_f, resc_f, first_pending;

  logic             mem_we, mem_re;
  logic [H_AW-1:0]  mem_waddr, mem_raddr;
  logic [VAL_W-1:0] mem_wdata, mem_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [ACC_W-1:0] var_gd, var_q, var_s, jac_d, jac_q, dp_sum, up_sum;
  logic signed [ACC_W-1:0] five_qs, diff5;
  logic                    col_ok;

  dbh_ram #(.WIDTH(VAL_W), .DEPTH(H_DEPTH)) u_hram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  dbh_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    if (vars_in_use == '0) begin
      n_act = CNT_W'(1);
    end else if (vars_in_use > CFG_W'(MAX_VARS)) begin
      n_act = CNT_W'(MAX_VARS);
    end else begin
      n_act = CNT_W'(vars_in_use);
    end
  end

  assign cfg_ready = 1'b1;
  assign ri_inc    = ri + 1'b1;
  assign cj_inc    = cj + 1'b1;
  assign last_i    = ri_inc == n_act;
  assign last_j    = cj_inc == n_act;
  assign vidx      = (state == ST_UP_ROW) ? ri[IDX_W-1:0] : cj[IDX_W-1:0];
  assign vq        = qd_vec[vidx];
  assign vs        = s_vec[vidx];
  assign vh        = hs_vec[vidx];
  assign rdata_s   = $signed(mem_rdata);
  assign acc_sat   = sat32(acc);
  assign acc_ovf   = ovf32(acc);
  assign col_ok    = CNT_W'(col_index) < n_act;

  assign var_gd  = ACC_W'(v3) - ACC_W'(v4);
  assign var_s   = ACC_W'(v1) - ACC_W'(v2);
  assign var_q   = ACC_W'(q_vec[col_index]) + ACC_W'(sat32(var_gd));
  assign jac_d   = ACC_W'(v1) - ACC_W'(v2);
  assign jac_q   = ACC_W'(q_vec[col_index]) + asr_q(prod);
  assign dp_sum  = tmp_a + asr_q(prod);
  assign up_sum  = ACC_W'(rdata_s) + ACC_W'(t1) - ACC_W'(t2);
  assign five_qs = (ACC_W'(qs) <<< 2) + ACC_W'(qs);
  assign diff5   = ((ACC_W'(shs) - ACC_W'(qs)) <<< 2) + (ACC_W'(shs) - ACC_W'(qs));

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      ST_JMUL: begin
        ma = MA_W'(dreg);
        mb = v3;
      end
      ST_DOT_MUL: begin
        unique case (kind)
          K_HROW: begin
            ma = MA_W'(rdata_s);
            mb = vs;
          end
          K_SHS: begin
            ma = MA_W'(vs);
            mb = vh;
          end
          K_QQ: begin
            ma = MA_W'(vq);
            mb = vq;
          end
          default: begin
            ma = MA_W'(vq);
            mb = vs;
          end
        endcase
      end
      ST_DP_M1: begin
        ma = MA_W'(th);
        mb = vq;
      end
      ST_DP_M2: begin
        ma = MA_W'(Q_ONE) - MA_W'(th);
        mb = vh;
      end
      ST_UP_M1: begin
        ma = MA_W'(qrow);
        mb = vq;
      end
      ST_UP_M2: begin
        ma = MA_W'(hrow);
        mb = vh;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    div_req    = '0;
    unique case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_addr;
        mem_wdata = (init_addr[H_AW-1:IDX_W] == init_addr[IDX_W-1:0]) ? Q_ONE : '0;
        if (init_addr == H_AW'(H_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (cmd)
          CMD_JAC:    state_next = col_ok ? ST_JSUB : ST_RESP;
          CMD_UPDATE: state_next = ST_U_START;
          CMD_READ:   state_next = ST_RD_ISSUE;
          default:    state_next = ST_RESP;
        endcase
      end
      ST_JSUB: state_next = ST_JMUL;
      ST_JMUL: state_next = ST_JACC;
      ST_JACC: state_next = ST_RESP;
      ST_RD_ISSUE: begin
        mem_re     = 1'b1;
        mem_raddr  = {row_index, col_index};
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      ST_U_START: state_next = ST_DOT_ISSUE;
      ST_DOT_ISSUE: begin
        mem_re     = 1'b1;
        mem_raddr  = {ri[IDX_W-1:0], cj[IDX_W-1:0]};
        state_next = ST_DOT_MUL;
      end
      ST_DOT_MUL: state_next = ST_DOT_ACC;
      ST_DOT_ACC: state_next = last_j ? ST_DOT_END : ST_DOT_ISSUE;
      ST_DOT_END: begin
        unique case (kind)
          K_SHS: begin
            if ((acc_sat < 0 || first_pending) && !resc_f) begin
              state_next = ST_DOT_ISSUE;
            end else begin
              state_next = ST_DP_CHECK;
            end
          end
          K_QQ:    state_next = ST_RS_GO;
          K_QS2:   state_next = ST_UP_ROW;
          default: state_next = ST_DOT_ISSUE;
        endcase
      end
      ST_RS_GO: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NUM_W'(qq) <<< FRAC_BITS;
        div_req.den   = DIV_DEN_W'(qs);
        state_next    = ST_RS_WAIT;
      end
      ST_RS_WAIT: begin
        if (div_rsp.done) begin
          state_next = ST_RS_WR;
        end
      end
      ST_RS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = {ri[IDX_W-1:0], cj[IDX_W-1:0]};
        mem_wdata = (ri == cj) ? scale : '0;
        if (last_i && last_j) begin
          state_next = ST_DOT_ISSUE;
        end
      end
      ST_DP_CHECK: state_next = (five_qs < ACC_W'(shs)) ? ST_DP_GO : ST_UP_ROW;
      ST_DP_GO: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NUM_W'(shs) <<< (FRAC_BITS + 2);
        div_req.den   = diff5[DIV_DEN_W-1:0];
        state_next    = ST_DP_WAIT;
      end
      ST_DP_WAIT: begin
        if (div_rsp.done) begin
          state_next = ST_DP_M1;
        end
      end
      ST_DP_M1:  state_next = ST_DP_M2;
      ST_DP_M2:  state_next = ST_DP_SUM;
      ST_DP_SUM: state_next = last_j ? ST_DOT_ISSUE : ST_DP_M1;
      ST_UP_ROW: state_next = ST_UP_M1;
      ST_UP_M1: begin
        mem_re     = 1'b1;
        mem_raddr  = {ri[IDX_W-1:0], cj[IDX_W-1:0]};
        state_next = ST_UP_D1;
      end
      ST_UP_D1: begin
        div_req.start = 1'b1;
        div_req.num   = prod[DIV_NUM_W-1:0];
        div_req.den   = DIV_DEN_W'(qs);
        state_next    = ST_UP_W1;
      end
      ST_UP_W1: begin
        if (div_rsp.done) begin
          state_next = ST_UP_M2;
        end
      end
      ST_UP_M2: state_next = ST_UP_D2;
      ST_UP_D2: begin
        div_req.start = 1'b1;
        div_req.num   = prod[DIV_NUM_W-1:0];
        div_req.den   = DIV_DEN_W'(shs);
        state_next    = ST_UP_W2;
      end
      ST_UP_W2: begin
        if (div_rsp.done) begin
          state_next = ST_UP_WR;
        end
      end
      ST_UP_WR: begin
        mem_we    = 1'b1;
        mem_waddr = {ri[IDX_W-1:0], cj[IDX_W-1:0]};
        mem_wdata = sat32(up_sum);
        if (last_j) begin
          state_next = last_i ? ST_RESP : ST_UP_ROW;
        end else begin
          state_next = ST_UP_M1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (rst) begin
      vars_in_use   <= CFG_W'(MAX_VARS);
      init_addr     <= '0;
      first_pending <= 1'b1;
      m_tvalid      <= 1'b0;
      sat_f         <= 1'b0;
      damp_f        <= 1'b0;
      resc_f        <= 1'b0;
      ri            <= '0;
      cj            <= '0;
      kind          <= K_QS;
      for (int k = 0; k < MAX_VARS; k++) begin
        s_vec[k] <= '0;
        q_vec[k] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        vars_in_use <= cfg_data;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_INIT: init_addr <= init_addr + 1'b1;
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd       <= s_tdata[2:0];
            row_index <= s_tdata[7:3];
            col_index <= s_tdata[12:8];
            v1        <= s_tdata[44:13];
            v2        <= s_tdata[76:45];
            v3        <= s_tdata[108:77];
            v4        <= s_tdata[140:109];
            sat_f     <= 1'b0;
            damp_f    <= 1'b0;
            resc_f    <= 1'b0;
            ri        <= '0;
            cj        <= '0;
          end
        end
        ST_EXEC: begin
          if (cmd == CMD_CLEAR) begin
            for (int k = 0; k < MAX_VARS; k++) begin
              s_vec[k] <= '0;
              q_vec[k] <= '0;
            end
          end else if (cmd == CMD_VAR && col_ok) begin
            s_vec[col_index] <= sat32(var_s);
            q_vec[col_index] <= sat32(var_q);
            sat_f <= ovf32(var_s) | ovf32(var_gd) | ovf32(var_q);
          end
        end
        ST_JSUB: begin
          dreg  <= sat32(jac_d);
          sat_f <= sat_f | ovf32(jac_d);
        end
        ST_JACC: begin
          q_vec[col_index] <= sat32(jac_q);
          sat_f <= sat_f | ovf32(jac_q);
        end
        ST_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'b0000, sat_f, resc_f, damp_f, cmd == CMD_UPDATE,
                         (cmd == CMD_READ) ? mem_rdata : {VAL_W{1'b0}}};
          end
        end
        ST_U_START: begin
          for (int k = 0; k < MAX_VARS; k++) begin
            qd_vec[k] <= q_vec[k];
          end
          kind <= K_QS;
          acc  <= '0;
          cj   <= '0;
          ri   <= '0;
        end
        ST_DOT_ACC: begin
          acc <= acc + asr_q(prod);
          cj  <= last_j ? '0 : cj_inc;
        end
        ST_DOT_END: begin
          acc   <= '0;
          cj    <= '0;
          sat_f <= sat_f | acc_ovf;
          unique case (kind)
            K_QS: begin
              qs   <= acc_sat;
              kind <= K_HROW;
              ri   <= '0;
            end
            K_HROW: begin
              hs_vec[ri[IDX_W-1:0]] <= acc_sat;
              if (last_i) begin
                kind <= K_SHS;
                ri   <= '0;
              end else begin
                ri <= ri_inc;
              end
            end
            K_SHS: begin
              shs  <= acc_sat;
              kind <= K_QQ;
              ri   <= '0;
            end
            K_QQ: qq <= acc_sat;
            default: begin
              qs <= acc_sat;
              ri <= '0;
            end
          endcase
        end
        ST_RS_WAIT: begin
          if (div_rsp.done) begin
            scale <= $signed(div_rsp.quot);
            sat_f <= sat_f | div_rsp.sat;
            ri    <= '0;
            cj    <= '0;
          end
        end
        ST_RS_WR: begin
          if (last_j) begin
            cj <= '0;
            if (last_i) begin
              ri            <= '0;
              kind          <= K_HROW;
              first_pending <= 1'b0;
              resc_f        <= 1'b1;
            end else begin
              ri <= ri_inc;
            end
          end else begin
            cj <= cj_inc;
          end
        end
        ST_DP_CHECK: begin
          ri <= '0;
          cj <= '0;
          if (five_qs < ACC_W'(shs)) begin
            damp_f <= 1'b1;
          end
        end
        ST_DP_WAIT: begin
          if (div_rsp.done) begin
            th    <= $signed(div_rsp.quot);
            sat_f <= sat_f | div_rsp.sat;
          end
        end
        ST_DP_M2: tmp_a <= asr_q(prod);
        ST_DP_SUM: begin
          qd_vec[cj[IDX_W-1:0]] <= sat32(dp_sum);
          sat_f <= sat_f | ovf32(dp_sum);
          if (last_j) begin
            cj   <= '0;
            acc  <= '0;
            kind <= K_QS2;
          end else begin
            cj <= cj_inc;
          end
        end
        ST_UP_ROW: begin
          qrow <= vq;
          hrow <= vh;
          cj   <= '0;
        end
        ST_UP_W1: begin
          if (div_rsp.done) begin
            t1    <= $signed(div_rsp.quot);
            sat_f <= sat_f | div_rsp.sat;
          end
        end
        ST_UP_W2: begin
          if (div_rsp.done) begin
            t2    <= $signed(div_rsp.quot);
            sat_f <= sat_f | div_rsp.sat;
          end
        end
        ST_UP_WR: begin
          sat_f <= sat_f | ovf32(up_sum);
          if (last_j) begin
            cj <= '0;
            ri <= ri_inc;
          end else begin
            cj <= cj_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_first_rescale: assert property (@(posedge clk) disable iff (rst)
    $fell(first_pending) |-> resc_f)
    else $error("first update closed without rescale");

  a_update_after_rescale: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UP_WR) |-> (resc_f || !first_pending))
    else $error("hessian written before first rescale");

  a_damp_in_update: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[33]) |-> m_tdata[32])
    else $error("damping flag outside update");

  a_resc_in_update: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[34]) |-> m_tdata[32])
    else $error("rescale flag outside update");
`endif

endmodule
